// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NOW(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Next-cycle implication: when cond holds, expect_next holds in the cycle after.
`define ASSERT_NEXT(label, cond, expect_next, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expect_next)) \
      else $error(msg);

`endif

// ===== hw/rtl/ser_pkg.sv =====
// Types, codes and element helpers shared by the scatter engine.
package ser_pkg;

   localparam int ADDR_FIELD_W = 12;
   localparam int CSR_IDX_W    = 3;

   localparam logic [1:0] FUNC_LOAD    = 2'd0;
   localparam logic [1:0] FUNC_SCATTER = 2'd1;
   localparam logic [1:0] FUNC_READ    = 2'd2;

   localparam logic [1:0] OP_NONE = 2'd0;
   localparam logic [1:0] OP_LOAD = 2'd1;
   localparam logic [1:0] OP_SCAT = 2'd2;
   localparam logic [1:0] OP_READ = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_ADDR  = 2'd2;

   localparam logic [2:0] MODE_NONE = 3'd0;
   localparam logic [2:0] MODE_ADD  = 3'd1;
   localparam logic [2:0] MODE_MUL  = 3'd2;
   localparam logic [2:0] MODE_MAX  = 3'd3;
   localparam logic [2:0] MODE_MIN  = 3'd4;

   localparam logic [1:0] ETYPE_INT8  = 2'd0;
   localparam logic [1:0] ETYPE_UINT8 = 2'd1;
   localparam logic [1:0] ETYPE_INT32 = 2'd2;
   localparam logic [1:0] ETYPE_INT64 = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_RANK   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ETYPE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DSHAPE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ISHAPE = 3'd5;

   localparam logic [63:0] SHAPE_RESET = 64'h0001_0001_0001_0001;

   typedef struct packed {
      logic [1:0]              func;
      logic [ADDR_FIELD_W-1:0] address;
      logic signed [31:0]      index_value;
      logic signed [63:0]      update_value;
   } req_item_type;

   typedef struct packed {
      logic signed [63:0] read_value;
      logic [1:0]         status;
   } rsp_item_type;

   typedef struct packed {
      logic [2:0] mode;
      logic [1:0] etype;
   } cfg_type;

   function automatic logic [63:0] wrap_elem(input logic [63:0] v, input logic [1:0] etype);
      logic [63:0] r;
      case (etype)
         ETYPE_INT8:  r = {{56{v[7]}}, v[7:0]};
         ETYPE_UINT8: r = {56'd0, v[7:0]};
         ETYPE_INT32: r = {{32{v[31]}}, v[31:0]};
         default:     r = v;
      endcase
      return r;
   endfunction

endpackage

// ===== hw/rtl/scatter_elements_reduce.sv =====
// Top level of the tensor scatter engine.
`include "assert_macros.svh"

// Scatter-elements engine. Load items fill the element store by flat address, scatter
// items combine an update into the element picked by the index tensor's odometer and the
// item's index, and read items return a stored element; every item gives exactly one
// result. The front end takes one item at a time and forms a scatter item's flat address
// one dimension per cycle through a single multiply-add. Behind a two-entry command
// queue, the back end writes a load straight to the store, handles a read or scatter as
// a registered store read followed by a response or write back, and runs a multiply
// scatter on one 32 by 32 multiplier in three steps. Results wait in a two-entry queue,
// so the back end keeps working while the consumer stalls, until that queue is full.
module scatter_elements_reduce
   import ser_pkg::*;
#(
   parameter int MAX_RANK    = 4,
   parameter int STORE_DEPTH = 4096,
   parameter int DIM_BITS    = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  req_item_type         req_item,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output rsp_item_type         rsp_item,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]          csr_data
);
   localparam int AW    = $clog2(STORE_DEPTH);
   localparam int CMD_W = 2 + AW + 64 + 2;
   localparam int RSP_W = $bits(rsp_item_type);

   cfg_type          cfg;
   logic             f_push, cmd_full, cmd_empty, cmd_pop, rsp_push, rsp_full;
   logic [1:0]       f_op, f_status;
   logic [AW-1:0]    f_addr;
   logic [63:0]      f_upd;
   logic [CMD_W-1:0] cmd_wdata, cmd_rdata;
   logic [RSP_W-1:0] rsp_wdata, rsp_rdata;
   rsp_item_type     b_item;

   ser_front #(.MAX_RANK(MAX_RANK), .STORE_DEPTH(STORE_DEPTH), .DIM_BITS(DIM_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_item   (req_item),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cfg_out    (cfg),
      .cmd_push   (f_push),
      .cmd_full   (cmd_full),
      .cmd_op     (f_op),
      .cmd_addr   (f_addr),
      .cmd_upd    (f_upd),
      .cmd_status (f_status)
   );

   assign cmd_wdata = {f_op, f_addr, f_upd, f_status};

   ser_fifo #(.WIDTH(CMD_W), .DEPTH(2)) u_cmd_q (
      .clock (clock),
      .reset (reset),
      .push  (f_push),
      .wdata (cmd_wdata),
      .full  (cmd_full),
      .pop   (cmd_pop),
      .rdata (cmd_rdata),
      .empty (cmd_empty)
   );

   ser_back #(.STORE_DEPTH(STORE_DEPTH)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd_empty  (cmd_empty),
      .cmd_pop    (cmd_pop),
      .cmd_op     (cmd_rdata[CMD_W-1 -: 2]),
      .cmd_addr   (cmd_rdata[AW+65:66]),
      .cmd_upd    (cmd_rdata[65:2]),
      .cmd_status (cmd_rdata[1:0]),
      .rsp_full   (rsp_full),
      .rsp_push   (rsp_push),
      .rsp_item   (b_item)
   );

   assign rsp_wdata = b_item;

   ser_fifo #(.WIDTH(RSP_W), .DEPTH(2)) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (rsp_wdata),
      .full  (rsp_full),
      .pop   (rsp_pop),
      .rdata (rsp_rdata),
      .empty (rsp_empty)
   );

   assign rsp_item = rsp_item_type'(rsp_rdata);

   `ASSERT_NOW(a_rsp_no_overflow, rsp_push |-> !rsp_full, "result pushed into a full queue")
   `ASSERT_NOW(a_cmd_pop_valid, cmd_pop |-> !cmd_empty, "command popped from an empty queue")
   `ASSERT_NEXT(a_front_busy, req_push && !req_full, req_full, "front took a second item early")
endmodule

// ===== hw/rtl/ser_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ser_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hw/rtl/ser_fifo.sv =====
// Small first-in first-out queue of fixed-width words.
module ser_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end
endmodule

// ===== hw/rtl/ser_front.sv =====
// Front end: configuration registers, odometer, item classification and address forming.
module ser_front
   import ser_pkg::*;
#(
   parameter int MAX_RANK    = 4,
   parameter int STORE_DEPTH = 4096,
   parameter int DIM_BITS    = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  req_item_type                  req_item,
   input  logic                          csr_write,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [63:0]                   csr_data,
   output cfg_type                       cfg_out,
   output logic                          cmd_push,
   input  logic                          cmd_full,
   output logic [1:0]                    cmd_op,
   output logic [$clog2(STORE_DEPTH)-1:0] cmd_addr,
   output logic [63:0]                   cmd_upd,
   output logic [1:0]                    cmd_status
);
   localparam int AW = $clog2(STORE_DEPTH);
   localparam int KW = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
   localparam int SW = AW + 1;
   localparam int PW = SW + DIM_BITS + 1;
   localparam logic [SW-1:0] DEPTH_LIM = SW'(STORE_DEPTH);

   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_CALC = 2'd1;
   localparam logic [1:0] F_PUSH = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [2:0]          rank_ff, rank_in, axis_ff, axis_in, mode_ff, mode_in;
   logic [1:0]          etype_ff, etype_in;
   logic [63:0]         dshape_ff, dshape_in, ishape_ff, ishape_in;
   logic [DIM_BITS-1:0] coord_ff [MAX_RANK];
   logic [DIM_BITS-1:0] coord_in [MAX_RANK];
   logic [DIM_BITS-1:0] odo_next [MAX_RANK];
   logic [1:0]          op_ff, op_in, status_ff, status_in;
   logic [SW-1:0]       addr_ff, addr_in;
   logic [63:0]         upd_ff, upd_in;
   logic                scat_ff, scat_in;
   logic [KW-1:0]       k_ff, k_in, ax_ff, ax_in;
   logic [DIM_BITS-1:0] idx_ff, idx_in;

   logic [3:0]          r_eff;
   logic signed [4:0]   ax_full;
   logic                axis_ok, idx_ok, addr_ok, accept, last, advance;
   logic [DIM_BITS-1:0] sel_dim, d_k, c_k;
   logic signed [33:0]  iv;
   logic [PW-1:0]       prod;
   logic [SW-1:0]       addr_next;

   function automatic logic [DIM_BITS-1:0] dim_of(input logic [63:0] shape,
                                                   input logic [KW-1:0] k);
      int          sh;
      logic [63:0] t;
      sh = DIM_BITS * (MAX_RANK - 1 - int'(k));
      if (sh >= 64 || sh < 0) begin
         return '0;
      end
      t = shape >> sh;
      return t[DIM_BITS-1:0];
   endfunction

   always_comb begin
      if (rank_ff == 3'd0) begin
         r_eff = 4'd1;
      end else if ({1'b0, rank_ff} > 4'(MAX_RANK)) begin
         r_eff = 4'(MAX_RANK);
      end else begin
         r_eff = {1'b0, rank_ff};
      end
   end

   always_comb begin
      ax_full = {{2{axis_ff[2]}}, axis_ff};
      if (ax_full < 0) begin
         ax_full = ax_full + $signed({1'b0, r_eff});
      end
      axis_ok  = (ax_full >= 0) && (ax_full < $signed({1'b0, r_eff}));
      sel_dim  = dim_of(dshape_ff, ax_full[KW-1:0]);
      iv = {{2{req_item.index_value[31]}}, req_item.index_value};
      if (iv < 0) begin
         iv = iv + $signed(34'(sel_dim));
      end
      idx_ok  = (iv >= 0) && (iv < $signed(34'(sel_dim)));
      addr_ok = (32'(req_item.address) < 32'(STORE_DEPTH));
   end

   always_comb begin
      d_k       = dim_of(dshape_ff, k_ff);
      c_k       = (k_ff == ax_ff) ? idx_ff : coord_ff[k_ff];
      prod      = PW'(addr_ff) * PW'(d_k) + PW'(c_k);
      addr_next = (prod > PW'(STORE_DEPTH)) ? DEPTH_LIM : prod[SW-1:0];
      last      = (32'(k_ff) == 32'(r_eff) - 32'd1);
   end

   always_comb begin
      logic                carry;
      logic [DIM_BITS:0]   nc;
      logic [DIM_BITS-1:0] d;
      carry = 1'b1;
      for (int k = 0; k < MAX_RANK; k++) begin
         odo_next[k] = coord_ff[k];
      end
      for (int k = MAX_RANK - 1; k >= 0; k--) begin
         d  = dim_of(ishape_ff, KW'(k));
         nc = {1'b0, coord_ff[k]} + 1'b1;
         if (carry && (k < int'(r_eff))) begin
            if (nc < {1'b0, d}) begin
               odo_next[k] = nc[DIM_BITS-1:0];
               carry       = 1'b0;
            end else begin
               odo_next[k] = '0;
            end
         end
      end
   end

   assign accept   = req_push && (state_ff == F_IDLE);
   assign req_full = (state_ff != F_IDLE);
   assign advance  = (state_ff == F_PUSH) && !cmd_full && scat_ff;

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      status_in = status_ff;
      addr_in   = addr_ff;
      upd_in    = upd_ff;
      scat_in   = scat_ff;
      k_in      = k_ff;
      ax_in     = ax_ff;
      idx_in    = idx_ff;
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               upd_in    = req_item.update_value;
               addr_in   = SW'(req_item.address);
               scat_in   = (req_item.func == FUNC_SCATTER);
               k_in      = '0;
               ax_in     = ax_full[KW-1:0];
               idx_in    = iv[DIM_BITS-1:0];
               status_in = ST_OK;
               op_in     = OP_NONE;
               state_in  = F_PUSH;
               case (req_item.func)
                  FUNC_LOAD: begin
                     op_in     = addr_ok ? OP_LOAD : OP_NONE;
                     status_in = addr_ok ? ST_OK : ST_ADDR;
                  end
                  FUNC_READ: begin
                     op_in     = addr_ok ? OP_READ : OP_NONE;
                     status_in = addr_ok ? ST_OK : ST_ADDR;
                  end
                  FUNC_SCATTER: begin
                     if (axis_ok && idx_ok) begin
                        addr_in  = '0;
                        state_in = F_CALC;
                     end else begin
                        status_in = ST_RANGE;
                     end
                  end
                  default: begin
                     op_in = OP_NONE;
                  end
               endcase
            end
         end
         F_CALC: begin
            if (c_k >= d_k) begin
               status_in = ST_RANGE;
               op_in     = OP_NONE;
               state_in  = F_PUSH;
            end else begin
               addr_in = addr_next;
               k_in    = k_ff + 1'b1;
               if (last) begin
                  state_in = F_PUSH;
                  if (addr_next >= DEPTH_LIM) begin
                     status_in = ST_ADDR;
                     op_in     = OP_NONE;
                  end else begin
                     status_in = ST_OK;
                     op_in     = (mode_ff > MODE_MIN) ? OP_NONE : OP_SCAT;
                  end
               end
            end
         end
         F_PUSH: begin
            if (!cmd_full) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_comb begin
      rank_in   = rank_ff;
      axis_in   = axis_ff;
      mode_in   = mode_ff;
      etype_in  = etype_ff;
      dshape_in = dshape_ff;
      ishape_in = ishape_ff;
      for (int k = 0; k < MAX_RANK; k++) begin
         coord_in[k] = advance ? odo_next[k] : coord_ff[k];
      end
      if (csr_write) begin
         case (csr_index)
            CSR_RANK:   rank_in   = csr_data[2:0];
            CSR_AXIS:   axis_in   = csr_data[2:0];
            CSR_MODE:   mode_in   = csr_data[2:0];
            CSR_ETYPE:  etype_in  = csr_data[1:0];
            CSR_DSHAPE: dshape_in = csr_data;
            CSR_ISHAPE: ishape_in = csr_data;
            default:    rank_in   = rank_ff;
         endcase
         if (csr_index == CSR_RANK || csr_index == CSR_ISHAPE) begin
            for (int k = 0; k < MAX_RANK; k++) begin
               coord_in[k] = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= F_IDLE;
         rank_ff   <= 3'd1;
         axis_ff   <= 3'd0;
         mode_ff   <= MODE_NONE;
         etype_ff  <= ETYPE_INT32;
         dshape_ff <= SHAPE_RESET;
         ishape_ff <= SHAPE_RESET;
         for (int k = 0; k < MAX_RANK; k++) begin
            coord_ff[k] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         rank_ff   <= rank_in;
         axis_ff   <= axis_in;
         mode_ff   <= mode_in;
         etype_ff  <= etype_in;
         dshape_ff <= dshape_in;
         ishape_ff <= ishape_in;
         for (int k = 0; k < MAX_RANK; k++) begin
            coord_ff[k] <= coord_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      status_ff <= status_in;
      addr_ff   <= addr_in;
      upd_ff    <= upd_in;
      scat_ff   <= scat_in;
      k_ff      <= k_in;
      ax_ff     <= ax_in;
      idx_ff    <= idx_in;
   end

   assign cmd_push      = (state_ff == F_PUSH);
   assign cmd_op        = op_ff;
   assign cmd_addr      = addr_ff[AW-1:0];
   assign cmd_upd       = upd_ff;
   assign cmd_status    = status_ff;
   assign cfg_out.mode  = mode_ff;
   assign cfg_out.etype = etype_ff;
endmodule

// ===== hw/rtl/ser_back.sv =====
// Back end: element store and read-modify-write execution of queued commands.
module ser_back
   import ser_pkg::*;
#(
   parameter int STORE_DEPTH = 4096
) (
   input  logic                           clock,
   input  logic                           reset,
   input  cfg_type                        cfg,
   input  logic                           cmd_empty,
   output logic                           cmd_pop,
   input  logic [1:0]                     cmd_op,
   input  logic [$clog2(STORE_DEPTH)-1:0] cmd_addr,
   input  logic [63:0]                    cmd_upd,
   input  logic [1:0]                     cmd_status,
   input  logic                           rsp_full,
   output logic                           rsp_push,
   output rsp_item_type                   rsp_item
);
   localparam int AW = $clog2(STORE_DEPTH);

   localparam logic [2:0] B_IDLE = 3'd0;
   localparam logic [2:0] B_DATA = 3'd1;
   localparam logic [2:0] B_M1   = 3'd2;
   localparam logic [2:0] B_M2   = 3'd3;
   localparam logic [2:0] B_M3   = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [1:0]    op_ff, op_in;
   logic [AW-1:0] addr_ff, addr_in, wr_addr;
   logic [63:0]   upd_ff, upd_in, a_ff, a_in, b_ff, b_in, prod_ff, prod_in;
   logic [63:0]   rd_data, wr_data, old_v, new_v, res;
   logic          wr_en;
   logic [31:0]   mul_a, mul_b;
   logic [63:0]   mul_out;

   ser_ram #(.WIDTH(64), .DEPTH(STORE_DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (cmd_addr),
      .rd_data (rd_data)
   );

   assign old_v   = wrap_elem(rd_data, cfg.etype);
   assign new_v   = wrap_elem(upd_ff, cfg.etype);
   assign mul_a   = (state_ff == B_M3) ? a_ff[63:32] : a_ff[31:0];
   assign mul_b   = (state_ff == B_M2) ? b_ff[63:32] : b_ff[31:0];
   assign mul_out = 64'(mul_a) * 64'(mul_b);

   always_comb begin
      case (cfg.mode)
         MODE_ADD: res = old_v + new_v;
         MODE_MAX: res = ($signed(old_v) > $signed(new_v)) ? old_v : new_v;
         MODE_MIN: res = ($signed(old_v) < $signed(new_v)) ? old_v : new_v;
         default:  res = new_v;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      addr_in  = addr_ff;
      upd_in   = upd_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      prod_in  = prod_ff;
      cmd_pop  = 1'b0;
      rsp_push = 1'b0;
      rsp_item = '0;
      wr_en    = 1'b0;
      wr_addr  = addr_ff;
      wr_data  = '0;
      case (state_ff)
         B_IDLE: begin
            if (!cmd_empty && !rsp_full) begin
               cmd_pop = 1'b1;
               op_in   = cmd_op;
               addr_in = cmd_addr;
               upd_in  = cmd_upd;
               case (cmd_op)
                  OP_LOAD: begin
                     wr_en           = 1'b1;
                     wr_addr         = cmd_addr;
                     wr_data         = cmd_upd;
                     rsp_push        = 1'b1;
                     rsp_item.status = ST_OK;
                  end
                  OP_READ, OP_SCAT: begin
                     state_in = B_DATA;
                  end
                  default: begin
                     rsp_push        = 1'b1;
                     rsp_item.status = cmd_status;
                  end
               endcase
            end
         end
         B_DATA: begin
            if (op_ff == OP_READ) begin
               rsp_push            = 1'b1;
               rsp_item.read_value = old_v;
               state_in            = B_IDLE;
            end else if (cfg.mode == MODE_MUL) begin
               a_in     = old_v;
               b_in     = new_v;
               state_in = B_M1;
            end else begin
               wr_en    = 1'b1;
               wr_data  = wrap_elem(res, cfg.etype);
               rsp_push = 1'b1;
               state_in = B_IDLE;
            end
         end
         B_M1: begin
            prod_in  = mul_out;
            state_in = B_M2;
         end
         B_M2: begin
            prod_in[63:32] = prod_ff[63:32] + mul_out[31:0];
            state_in       = B_M3;
         end
         B_M3: begin
            wr_en    = 1'b1;
            wr_data  = wrap_elem({prod_ff[63:32] + mul_out[31:0], prod_ff[31:0]}, cfg.etype);
            rsp_push = 1'b1;
            state_in = B_IDLE;
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      addr_ff <= addr_in;
      upd_ff  <= upd_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      prod_ff <= prod_in;
   end
endmodule
